// ===== src/arp_acd_pkg.sv =====
// Shared types and constants for the ARP address conflict detector.
// No dependencies; imported by the detector, its checker and its testbench.
package arp_acd_pkg;

  // Request opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_PACKET = 2'd2;

  // Why the scan stopped early
  localparam logic [1:0] HOLD_NONE     = 2'd0;
  localparam logic [1:0] HOLD_FIRST    = 2'd1;
  localparam logic [1:0] HOLD_INTERVAL = 2'd2;

  // Configuration register map (word index) and reset value
  localparam logic REG_DEFEND_INTERVAL = 1'b0;
  localparam logic [31:0] DEFEND_INTERVAL_RESET = 32'd10000;

  // One table word: addresses and time of the last acted-on conflict
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] last_ms;
  } iface_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOCAL,
    ST_SCAN,
    ST_DONE
  } acd_state_t;

endpackage

// ===== src/arp_address_conflict_detector.sv =====
// ARP address conflict detector: load and tick requests are taken while idle and leave it idle.
// An ARP packet request runs a local MAC pass and then a conflict scan, each through the
// registered table read port, and its result goes to the output register; either pass
// may stop early. No new request is taken until the result has entered the output register;
// a stalled result holds it.
// Synchronous active-high reset clears entry flags, clock and result valid; interval 10000 ms.
module arp_address_conflict_detector #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [2:0]  entry_index,
  input  logic [31:0] entry_ip,
  input  logic [47:0] entry_mac,
  input  logic        entry_usable,
  input  logic        entry_defend,
  input  logic [31:0] sender_ip,
  input  logic [47:0] sender_mac,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        from_local,
  output logic        conflict,
  output logic [7:0]  notify_mask,
  output logic [7:0]  defend_mask,
  output logic [1:0]  hold_reason,
  output logic [2:0]  hold_entry,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import arp_acd_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int XW = IW + 3;
  localparam int WW = $bits(iface_word_t);

  acd_state_t state, state_next;

  logic [IW:0]         cnt;
  logic                ev_valid;
  logic [IW-1:0]       ev_idx;
  logic [31:0]         sip;
  logic [47:0]         smac;
  logic [31:0]         now_ms;
  logic [31:0]         interval;
  logic [ENTRIES-1:0]  usable;
  logic [ENTRIES-1:0]  defend;
  logic [ENTRIES-1:0]  seen;

  logic                res_local;
  logic [7:0]          res_notify;
  logic [7:0]          res_defend;
  logic [1:0]          res_reason;
  logic [2:0]          res_hold;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  iface_word_t         ram_wdata;
  logic [WW-1:0]       ram_rdata;
  iface_word_t         rd;

  logic                in_fire, issue, ev_end, done_fire;
  logic                usable_ev, mac_eq, local_hit, ip_hit, in_window, act;
  logic [31:0]         elapsed;
  logic [XW-1:0]       ev_ext, ld_ext;
  logic                below8, ld_ok;

  // Table RAM: IP, MAC and last conflict time of each entry
  arp_acd_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd = iface_word_t'(ram_rdata);

  // Handshakes
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign done_fire = (state == ST_DONE) && (!out_valid || !out_stall);
  assign issue     = (cnt < (IW+1)'(ENTRIES));

  // Entry index helpers
  assign ev_ext = XW'(ev_idx);
  assign below8 = (ev_ext < XW'(8));
  assign ld_ext = XW'(entry_index);
  assign ld_ok  = (ld_ext < XW'(ENTRIES));

  // Compare the word read last cycle against the held packet
  assign usable_ev = usable[ev_idx];
  assign mac_eq    = (rd.mac == smac);
  assign local_hit = ev_valid && usable_ev && mac_eq;
  assign ip_hit    = ev_valid && usable_ev && (rd.ip == sip) && !mac_eq;
  assign elapsed   = now_ms - rd.last_ms;
  assign in_window = (elapsed < interval);
  assign act       = ip_hit && (!seen[ev_idx] || !in_window);
  assign ev_end    = ev_valid && (ev_idx == IW'(ENTRIES - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && opcode == OP_PACKET) begin
          state_next = ST_LOCAL;
        end
      end
      ST_LOCAL: begin
        if (local_hit) begin
          state_next = ST_DONE;
        end else if (ev_end) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ip_hit && (!seen[ev_idx] || in_window)) begin
          state_next = ST_DONE;
        end else if (ev_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Table writes: entry load, or time stamp of an acted-on conflict
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = '{ip: rd.ip, mac: rd.mac, last_ms: now_ms};
    if (state == ST_IDLE && in_fire && opcode == OP_LOAD && ld_ok) begin
      ram_we    = 1'b1;
      ram_waddr = ld_ext[IW-1:0];
      ram_wdata = '{ip: entry_ip, mac: entry_mac, last_ms: 32'd0};
    end else if (state == ST_SCAN && act) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer counters, entry flags and clock
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      ev_valid <= 1'b0;
      usable   <= '0;
      defend   <= '0;
      seen     <= '0;
      now_ms   <= '0;
    end else begin
      if (state == ST_LOCAL || state == ST_SCAN) begin
        if (state == ST_LOCAL && state_next == ST_SCAN) begin
          cnt      <= '0;
          ev_valid <= 1'b0;
        end else begin
          cnt      <= cnt + (IW+1)'(issue);
          ev_valid <= issue;
        end
      end else begin
        cnt      <= '0;
        ev_valid <= 1'b0;
      end
      if (in_fire && opcode == OP_TICK) begin
        now_ms <= now_ms + 32'd1;
      end
      if (in_fire && opcode == OP_LOAD && ld_ok) begin
        usable[ld_ext[IW-1:0]] <= entry_usable;
        defend[ld_ext[IW-1:0]] <= entry_defend;
        seen[ld_ext[IW-1:0]]   <= 1'b0;
      end
      if (state == ST_SCAN && ip_hit && !seen[ev_idx]) begin
        seen[ev_idx] <= 1'b1;
      end
    end
  end

  // Hold the packet and gather its result
  always_ff @(posedge clk) begin
    ev_idx <= cnt[IW-1:0];
    if (in_fire && opcode == OP_PACKET) begin
      sip        <= sender_ip;
      smac       <= sender_mac;
      res_local  <= 1'b0;
      res_notify <= '0;
      res_defend <= '0;
      res_reason <= HOLD_NONE;
      res_hold   <= '0;
    end
    if (state == ST_LOCAL && local_hit) begin
      res_local <= 1'b1;
    end
    if (state == ST_SCAN && ip_hit) begin
      if (!seen[ev_idx]) begin
        res_reason <= HOLD_FIRST;
        res_hold   <= ev_ext[2:0];
      end else if (in_window) begin
        res_reason <= HOLD_INTERVAL;
        res_hold   <= ev_ext[2:0];
      end else if (below8) begin
        res_notify[ev_ext[2:0]] <= 1'b1;
        res_defend[ev_ext[2:0]] <= defend[ev_idx];
      end
    end
  end

  // Output register: a finished request waits here for the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= done_fire || (out_valid && out_stall);
    end
    if (done_fire) begin
      from_local  <= res_local;
      conflict    <= (res_notify != 8'd0);
      notify_mask <= res_notify;
      defend_mask <= res_defend;
      hold_reason <= res_reason;
      hold_entry  <= res_hold;
    end
  end

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEFEND_INTERVAL) ? interval : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= DEFEND_INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_DEFEND_INTERVAL) begin
      interval <= pwdata;
    end
  end

`ifndef SYNTHESIS
  a_defend_in_notify: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((defend_mask & ~notify_mask) == 8'd0))
    else $error("defend bit without notify bit");

  a_local_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && from_local) |-> (!conflict && notify_mask == 8'd0 &&
                                   hold_reason == HOLD_NONE))
    else $error("local packet carries conflict fields");

  a_hold_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hold_reason == HOLD_NONE) |-> (hold_entry == 3'd0))
    else $error("hold entry set without a hold reason");

  a_scan_no_load: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == ST_SCAN) |-> ev_valid)
    else $error("table written in scan without an evaluated entry");
`endif

endmodule

// ===== src/arp_acd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the interface table of the conflict detector.
module arp_acd_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/arp_conflict_checker.sv =====
// Checker for the ARP address conflict detector: keeps its own copy of the
// interface table, predicts the verdict of every ARP packet request and
// compares it with the result channel. Depends on arp_acd_pkg.
module arp_conflict_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [2:0]  entry_index,
  input  logic [31:0] entry_ip,
  input  logic [47:0] entry_mac,
  input  logic        entry_usable,
  input  logic        entry_defend,
  input  logic [31:0] sender_ip,
  input  logic [47:0] sender_mac,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        from_local,
  input  logic        conflict,
  input  logic [7:0]  notify_mask,
  input  logic [7:0]  defend_mask,
  input  logic [1:0]  hold_reason,
  input  logic [2:0]  hold_entry,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import arp_acd_pkg::*;

  localparam int TABLE_SIZE = 8;
  localparam int PRINT_LIMIT = 40;
  localparam logic [2:0] DEFEND_ADDR = {REG_DEFEND_INTERVAL, 2'b00};

  typedef struct packed {
    logic       from_local;
    logic       conflict;
    logic [7:0] notify_mask;
    logic [7:0] defend_mask;
    logic [1:0] hold_reason;
    logic [2:0] hold_entry;
  } verdict_t;

  iface_word_t           iface_tab [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] usable_q;
  logic [TABLE_SIZE-1:0] defends_q;
  logic [TABLE_SIZE-1:0] seen_q;
  logic [31:0]           now_ms_q;
  logic [31:0]           interval_q;
  verdict_t              due_verdicts [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  // Print one line per mismatch (up to a limit) and count it
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Work out the verdict of one ARP packet and update the table history
  function automatic verdict_t judge_packet(input logic [31:0] sip,
                                            input logic [47:0] smac);
    verdict_t    v;
    logic        stop;
    logic [31:0] elapsed;
    v = '0;
    stop = 1'b0;
    for (int i = 0; i < TABLE_SIZE; i++)
      if (usable_q[i] && iface_tab[i].mac == smac) v.from_local = 1'b1;
    if (v.from_local) return v;
    for (int i = 0; i < TABLE_SIZE && !stop; i++) begin
      if (usable_q[i] && iface_tab[i].ip == sip && iface_tab[i].mac != smac) begin
        elapsed = now_ms_q - iface_tab[i].last_ms;
        if (!seen_q[i]) begin
          // first sighting: remember the time and stop
          seen_q[i] = 1'b1;
          iface_tab[i].last_ms = now_ms_q;
          v.hold_reason = HOLD_FIRST;
          v.hold_entry = 3'(i);
          stop = 1'b1;
        end else if (elapsed < interval_q) begin
          v.hold_reason = HOLD_INTERVAL;
          v.hold_entry = 3'(i);
          stop = 1'b1;
        end else begin
          iface_tab[i].last_ms = now_ms_q;
          v.notify_mask[i] = 1'b1;
          if (defends_q[i]) v.defend_mask[i] = 1'b1;
        end
      end
    end
    v.conflict = |v.notify_mask;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) iface_tab[i] = '0;
      usable_q = '0;
      defends_q = '0;
      seen_q = '0;
      now_ms_q = '0;
      interval_q = DEFEND_INTERVAL_RESET;
      due_verdicts.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready && paddr == DEFEND_ADDR)
        interval_q = pwdata;

      // compare each accepted result with the oldest due verdict
      if (out_valid && !out_stall) begin
        got = {from_local, conflict, notify_mask, defend_mask, hold_reason, hold_entry};
        if (due_verdicts.size() == 0) begin
          flag_mismatch("result with no request waiting", got, '0);
        end else begin
          want = due_verdicts.pop_front();
          if (got.from_local !== want.from_local)
            flag_mismatch("from_local", got.from_local, want.from_local);
          if (got.conflict !== want.conflict)
            flag_mismatch("conflict", got.conflict, want.conflict);
          if (got.notify_mask !== want.notify_mask)
            flag_mismatch("notify_mask", got.notify_mask, want.notify_mask);
          if (got.defend_mask !== want.defend_mask)
            flag_mismatch("defend_mask", got.defend_mask, want.defend_mask);
          if (got.hold_reason !== want.hold_reason)
            flag_mismatch("hold_reason", got.hold_reason, want.hold_reason);
          if (got.hold_entry !== want.hold_entry)
            flag_mismatch("hold_entry", got.hold_entry, want.hold_entry);
        end
      end

      // advance the mirrored state on each accepted request
      if (in_valid && !in_stall) begin
        case (opcode)
          OP_LOAD: begin
            iface_tab[entry_index].ip = entry_ip;
            iface_tab[entry_index].mac = entry_mac;
            iface_tab[entry_index].last_ms = '0;
            usable_q[entry_index] = entry_usable;
            defends_q[entry_index] = entry_defend;
            seen_q[entry_index] = 1'b0;
          end
          OP_TICK: begin
            now_ms_q = now_ms_q + 32'd1;
          end
          OP_PACKET: begin
            due_verdicts.push_back(judge_packet(sender_ip, sender_mac));
          end
          default: begin
            // spare opcode: drop
          end
        endcase
      end
    end
    pending = due_verdicts.size();
  end

endmodule

// ===== test/tb_arp_address_conflict_detector.sv =====
// Testbench top for the ARP address conflict detector: drives requests,
// register writes and result back-pressure, and gives the verdict.
// Depends on arp_acd_pkg, the block and arp_conflict_checker.
module tb_arp_address_conflict_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import arp_acd_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [2:0] DEFEND_ADDR = {REG_DEFEND_INTERVAL, 2'b00};
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 112;
  localparam int QUIET_CYCLES = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  idx;
    logic [31:0] eip;
    logic [47:0] emac;
    logic        eu;
    logic        ed;
    logic [31:0] sip;
    logic [47:0] smac;
  } request_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [2:0]  entry_index;
  logic [31:0] entry_ip;
  logic [47:0] entry_mac;
  logic        entry_usable;
  logic        entry_defend;
  logic [31:0] sender_ip;
  logic [47:0] sender_mac;
  logic        out_valid;
  logic        out_stall;
  logic        from_local;
  logic        conflict;
  logic [7:0]  notify_mask;
  logic [7:0]  defend_mask;
  logic [1:0]  hold_reason;
  logic [2:0]  hold_entry;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;

  // small address pools so that conflicts and repeats actually happen
  logic [31:0] ip_pool [4];
  logic [47:0] entry_mac_pool [4];
  logic [47:0] sender_mac_pool [2];
  bit          gaps_on;
  bit          hold_off_go;
  bit          hold_off_done;

  arp_address_conflict_detector dut (.*);
  arp_conflict_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic request_t junk();
    request_t r;
    r.op = 2'($urandom_range(0, 3));
    r.idx = 3'($urandom_range(0, 7));
    r.eip = $urandom();
    r.emac = rand48();
    r.eu = 1'($urandom_range(0, 1));
    r.ed = 1'($urandom_range(0, 1));
    r.sip = $urandom();
    r.smac = rand48();
    return r;
  endfunction

  function automatic request_t load_req(input logic [2:0] idx, input logic [31:0] ip,
                                        input logic [47:0] mac, input logic u,
                                        input logic d);
    request_t r;
    r = junk();
    r.op = OP_LOAD;
    r.idx = idx;
    r.eip = ip;
    r.emac = mac;
    r.eu = u;
    r.ed = d;
    return r;
  endfunction

  function automatic request_t packet_req(input logic [31:0] ip, input logic [47:0] mac);
    request_t r;
    r = junk();
    r.op = OP_PACKET;
    r.sip = ip;
    r.smac = mac;
    return r;
  endfunction

  function automatic request_t tick_req();
    request_t r;
    r = junk();
    r.op = OP_TICK;
    return r;
  endfunction

  // Mostly well-formed traffic drawn from the pools, with some noise
  function automatic request_t make_request();
    request_t r;
    int       k;
    int       m;
    r = junk();
    k = $urandom_range(0, 99);
    if (k < 3) begin
      r.op = OP_SPARE;
    end else if (k < 18) begin
      r.op = OP_LOAD;
      if ($urandom_range(0, 4) != 0) r.eip = ip_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) != 0) r.emac = entry_mac_pool[$urandom_range(0, 3)];
      r.eu = ($urandom_range(0, 4) != 0);
    end else if (k < 50) begin
      r.op = OP_TICK;
    end else begin
      r.op = OP_PACKET;
      if ($urandom_range(0, 9) < 8) r.sip = ip_pool[$urandom_range(0, 3)];
      m = $urandom_range(0, 9);
      if (m < 3) r.smac = entry_mac_pool[$urandom_range(0, 3)];
      else if (m < 7) r.smac = sender_mac_pool[$urandom_range(0, 1)];
    end
    return r;
  endfunction

  // Offer one request after an optional gap; hold it until accepted
  task automatic offer(input request_t r);
    int gap;
    int k;
    gap = 0;
    if (gaps_on) begin
      k = $urandom_range(0, 99);
      if (k < 55) gap = 0;
      else if (k < 88) gap = $urandom_range(1, 3);
      else if (k < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {opcode, entry_index, entry_ip, entry_mac, entry_usable, entry_defend,
     sender_ip, sender_mac} <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_interval(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DEFEND_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Result back-pressure: short stalls mostly, a few long, one long hold-off
  initial begin
    int busy;
    int idle;
    int k;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_go && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      busy = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      out_stall <= 1'b0;
      repeat (busy) @(negedge clk);
      k = $urandom_range(0, 19);
      if (k == 0) idle = $urandom_range(20, 80);
      else if (k < 6) idle = 0;
      else idle = $urandom_range(1, 4);
      if (idle > 0) begin
        out_stall <= 1'b1;
        repeat (idle) @(negedge clk);
      end
    end
  end

  initial begin
    logic [31:0] phase_interval [RANDOM_PHASES];
    rst = 1'b1;
    in_valid = 1'b0;
    {opcode, entry_index, entry_ip, entry_mac, entry_usable, entry_defend,
     sender_ip, sender_mac} = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    hold_off_go = 1'b0;
    hold_off_done = 1'b0;
    ip_pool = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), $urandom()};
    entry_mac_pool = '{48'h0, 48'hFFFF_FFFF_FFFF, rand48(), rand48()};
    sender_mac_pool = '{rand48(), rand48()};
    phase_interval = '{32'd1, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'd2,
                       DEFEND_INTERVAL_RESET, 32'd6, 32'($urandom_range(0, 20))};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset interval, empty table, local, first sighting, hold
    offer(packet_req(32'h0, 48'h0));
    offer(load_req(3'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1));
    offer(load_req(3'd7, 32'h0, 48'h0, 1'b1, 1'b0));
    offer(load_req(3'd3, 32'h0A00_0003, 48'h0200_0000_0003, 1'b0, 1'b1));
    offer(load_req(3'd1, 32'hFFFF_FFFF, 48'h0200_0000_0001, 1'b1, 1'b0));
    offer(packet_req(32'h1234_5678, 48'hFFFF_FFFF_FFFF));
    offer(packet_req(32'hFFFF_FFFF, 48'h0200_0000_00AA));
    offer(packet_req(32'hFFFF_FFFF, 48'h0200_0000_00AA));
    offer(packet_req(32'h0, 48'h0200_0000_00AA));
    offer(packet_req(32'h0A00_0003, 48'h0200_0000_00AA));
    begin
      request_t spare;
      spare = junk();
      spare.op = OP_SPARE;
      offer(spare);
    end
    offer(tick_req());

    // Directed: zero interval, notify with the scan going on, reload clears history
    settle();
    write_interval(32'd0);
    offer(packet_req(32'hFFFF_FFFF, 48'h0200_0000_00AA));
    offer(packet_req(32'hFFFF_FFFF, 48'h0200_0000_00AA));
    offer(packet_req(32'h0, 48'h0200_0000_00AA));
    offer(load_req(3'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1));
    offer(packet_req(32'hFFFF_FFFF, 48'h0200_0000_00AA));

    // Directed: largest interval holds every repeat
    settle();
    write_interval(32'hFFFF_FFFF);
    offer(packet_req(32'hFFFF_FFFF, 48'h0200_0000_00AA));
    offer(tick_req());
    offer(packet_req(32'h0, 48'h0));

    // Random phases, each with its own defend interval
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      write_interval(phase_interval[p]);
      gaps_on = (p % 3 != 2);
      if (p == 0) hold_off_go = 1'b1;
      repeat (ITEMS_PER_PHASE) offer(make_request());
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/arp_acd_pkg.sv
src/arp_acd_ram.sv
src/arp_address_conflict_detector.sv
test/arp_conflict_checker.sv
test/tb_arp_address_conflict_detector.sv
